/* design/rsgg_pkg.sv */
// Shared types and constants of the ratchet step gate generator.
package rsgg_pkg;

  // Field widths fixed by the register map and the sample formats.
  localparam int TICK_W     = 24;
  localparam int FRAC_W     = 17;
  localparam int BURST_W    = 7;
  localparam int CVB_W      = 15;
  localparam int CODE_W     = 16;
  localparam int GATE_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q16 unity and the 10 V full-scale code (3200 codes per volt).
  localparam logic [FRAC_W-1:0] Q16_ONE    = 17'h10000;
  localparam logic [GATE_W-1:0] FULL_SCALE = 15'd32000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TICKS      = 3'd0,
    CFG_GATE_FRACTION   = 3'd1,
    CFG_RETRIG_FRACTION = 3'd2,
    CFG_OFFSET_FRACTION = 3'd3,
    CFG_NUM_RETRIGS     = 3'd4,
    CFG_PLAY_PROB       = 3'd5,
    CFG_ALT_PROB        = 3'd6,
    CFG_CV_BASE         = 3'd7
  } cfg_reg_t;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_MUL_GATE   = 7'b0000010,
    ST_MUL_RETRIG = 7'b0000100,
    ST_MUL_OFFSET = 7'b0001000,
    ST_PREP       = 7'b0010000,
    ST_DIV        = 7'b0100000,
    ST_DONE       = 7'b1000000
  } state_t;

endpackage

/* design/rsgg_in_if.sv */
// Input word channel of the ratchet step gate generator.
interface rsgg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 start_event;
  logic                                 inhibit_event;
  logic                                 mute_toggle;
  logic                                 cv_stack_toggle;
  logic                                 gate_stack_toggle;
  logic signed [rsgg_pkg::CODE_W-1:0]   gate_in;
  logic signed [rsgg_pkg::CODE_W-1:0]   cv_mod_in;
  logic signed [rsgg_pkg::CODE_W-1:0]   cv_chain_in;
  logic        [rsgg_pkg::CODE_W-1:0]   rand_play;
  logic        [rsgg_pkg::CODE_W-1:0]   rand_alt;

  modport source (
    output valid, start_event, inhibit_event, mute_toggle, cv_stack_toggle,
           gate_stack_toggle, gate_in, cv_mod_in, cv_chain_in, rand_play, rand_alt,
    input  ready
  );
  modport sink (
    input  valid, start_event, inhibit_event, mute_toggle, cv_stack_toggle,
           gate_stack_toggle, gate_in, cv_mod_in, cv_chain_in, rand_play, rand_alt,
    output ready
  );
endinterface

/* design/rsgg_out_if.sv */
// Result word channel of the ratchet step gate generator.
interface rsgg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [rsgg_pkg::GATE_W-1:0]   gate_out;
  logic signed [rsgg_pkg::CODE_W-1:0]   cv_out;
  logic                                 end_pulse;
  logic                                 alt_end_pulse;
  logic                                 step_active;

  modport source (
    output valid, gate_out, cv_out, end_pulse, alt_end_pulse, step_active,
    input  ready
  );
  modport sink (
    input  valid, gate_out, cv_out, end_pulse, alt_end_pulse, step_active,
    output ready
  );
endinterface

/* design/rsgg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module rsgg_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVIDEND_W-1:0] remainder
);

  localparam int CMP_W = (DIVIDEND_W > DIVISOR_W ? DIVIDEND_W : DIVISOR_W) + 1;
  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W-1:0] rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;

  logic [CMP_W-1:0]      trial;
  logic [CMP_W-1:0]      dsr_ext;
  logic                  fits;
  logic [CMP_W-1:0]      diff;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial   = CMP_W'({rem_r, quo_r[DIVIDEND_W-1]});
    dsr_ext = CMP_W'(dsr_r);
    fits    = trial >= dsr_ext;
    diff    = trial - dsr_ext;
  end

  // Control: count the iterations and flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits leave at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[DIVIDEND_W-1:0] : trial[DIVIDEND_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* design/ratchet_step_gate_generator.sv */
// Top level of the ratchet step gate generator.
// One input word per audio tick. A word is taken only while the sequencer is idle and gives
// exactly one result word. An idle tick, or the final tick of a step, goes from idle straight
// to the done state. A tick inside a running step makes three passes of the shared 17x24
// multiplier for the gate, spacing and offset tick counts, then a prep state, and, when the
// burst position needs a division, the restoring divider takes one elapsed-count bit per cycle.
// The next word may be taken while a result still waits in the output register. The user must
// write configuration through the cfg_ port between words; the block itself does not enforce it.
module ratchet_step_gate_generator #(
  parameter int COUNT_WIDTH = 24,
  parameter int PULSE_TICKS = 10,
  parameter int MAX_RETRIGS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsgg_in_if.sink                         in_ch,
  rsgg_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rsgg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsgg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW    = rsgg_pkg::TICK_W;
  localparam int FW    = rsgg_pkg::FRAC_W;
  localparam int CW    = rsgg_pkg::CODE_W;
  localparam int GW    = rsgg_pkg::GATE_W;
  localparam int CMP_W = (COUNT_WIDTH > TW ? COUNT_WIDTH : TW) + 1;
  localparam int PW    = $clog2(PULSE_TICKS + 1);
  localparam int PROD_W = FW + TW;

  // Configuration registers.
  logic [TW-1:0]                     step_ticks_r;
  logic [FW-1:0]                     gate_fraction_r;
  logic [FW-1:0]                     retrig_fraction_r;
  logic [FW-1:0]                     offset_fraction_r;
  logic [rsgg_pkg::BURST_W-1:0]      num_retrigs_r;
  logic [FW-1:0]                     play_prob_r;
  logic [FW-1:0]                     alt_prob_r;
  logic [rsgg_pkg::CVB_W-1:0]        cv_base_r;

  // Step state.
  rsgg_pkg::state_t                  state_r;
  logic                              running_r;
  logic [COUNT_WIDTH-1:0]            ticks_left_r;
  logic [COUNT_WIDTH-1:0]            elapsed_r;
  logic                              play_r;
  logic                              alt_r;
  logic                              mute_r;
  logic                              cv_stack_r;
  logic                              gate_stack_r;
  logic [PW-1:0]                     pulse_left_r;

  // Latched samples and derived tick counts.
  logic signed [CW-1:0]              gate_in_r;
  logic signed [CW-1:0]              cv_mod_r;
  logic signed [CW-1:0]              cv_chain_r;
  logic [TW-1:0]                     glen_r;
  logic [TW-1:0]                     dist_r;
  logic [TW-1:0]                     offs_r;
  logic [COUNT_WIDTH-1:0]            mult_r;
  logic [COUNT_WIDTH-1:0]            rem_r;
  logic                              ge_offs_r;

  // Output register.
  logic                              out_valid_r;
  logic [GW-1:0]                     gate_out_r;
  logic signed [CW-1:0]              cv_out_r;
  logic                              end_pulse_r;
  logic                              alt_end_pulse_r;
  logic                              step_active_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r      <= TW'(48000);
      gate_fraction_r   <= rsgg_pkg::Q16_ONE;
      retrig_fraction_r <= rsgg_pkg::Q16_ONE;
      offset_fraction_r <= '0;
      num_retrigs_r     <= rsgg_pkg::BURST_W'(1);
      play_prob_r       <= rsgg_pkg::Q16_ONE;
      alt_prob_r        <= '0;
      cv_base_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsgg_pkg::CFG_STEP_TICKS:      step_ticks_r      <= cfg_data[TW-1:0];
        rsgg_pkg::CFG_GATE_FRACTION:   gate_fraction_r   <= cfg_data[FW-1:0];
        rsgg_pkg::CFG_RETRIG_FRACTION: retrig_fraction_r <= cfg_data[FW-1:0];
        rsgg_pkg::CFG_OFFSET_FRACTION: offset_fraction_r <= cfg_data[FW-1:0];
        rsgg_pkg::CFG_NUM_RETRIGS:     num_retrigs_r     <= cfg_data[rsgg_pkg::BURST_W-1:0];
        rsgg_pkg::CFG_PLAY_PROB:       play_prob_r       <= cfg_data[FW-1:0];
        rsgg_pkg::CFG_ALT_PROB:        alt_prob_r        <= cfg_data[FW-1:0];
        rsgg_pkg::CFG_CV_BASE:         cv_base_r         <= cfg_data[rsgg_pkg::CVB_W-1:0];
        default: ;
      endcase
    end
  end

  // Word acceptance and the effect of start, toggles and inhibit.
  logic                   in_ready;
  logic                   accept;
  logic                   start_now;
  logic                   running_nxt;
  logic [COUNT_WIDTH-1:0] ticks_left_nxt;
  logic                   play_nxt;
  logic                   alt_nxt;

  assign in_ready = (state_r == rsgg_pkg::ST_IDLE);
  assign accept   = in_ready && in_ch.valid;

  always_comb begin
    start_now      = !running_r && in_ch.start_event;
    running_nxt    = (running_r || start_now) && !in_ch.inhibit_event;
    ticks_left_nxt = start_now ? COUNT_WIDTH'(step_ticks_r) : ticks_left_r;
    play_nxt       = ({2'b00, in_ch.rand_play} + {1'b0, play_prob_r})
                     >= {1'b0, rsgg_pkg::Q16_ONE};
    alt_nxt        = ({2'b00, in_ch.rand_alt} + {1'b0, alt_prob_r})
                     > {1'b0, rsgg_pkg::Q16_ONE};
  end

  // Shared multiplier: clamped Q16 fraction times the step length.
  logic [FW-1:0]     frac_sel;
  logic [FW-1:0]     frac_cl;
  logic [PROD_W-1:0] product;
  logic [TW-1:0]     frac_ticks;

  always_comb begin
    case (state_r)
      rsgg_pkg::ST_MUL_GATE:   frac_sel = gate_fraction_r;
      rsgg_pkg::ST_MUL_RETRIG: frac_sel = retrig_fraction_r;
      default:                 frac_sel = offset_fraction_r;
    endcase
    frac_cl    = (frac_sel > rsgg_pkg::Q16_ONE) ? rsgg_pkg::Q16_ONE : frac_sel;
    product    = PROD_W'(frac_cl) * PROD_W'(step_ticks_r);
    frac_ticks = product[16 +: TW];
  end

  // Position of the elapsed count against the first burst.
  logic [CMP_W-1:0]       el_ext;
  logic [CMP_W-1:0]       offs_ext;
  logic [CMP_W-1:0]       el_diff;
  logic                   el_ge;
  logic                   el_gt;
  logic                   div_start;
  logic                   div_done;
  logic [COUNT_WIDTH-1:0] div_quo;
  logic [COUNT_WIDTH-1:0] div_rem;

  always_comb begin
    el_ext    = CMP_W'(elapsed_r);
    offs_ext  = CMP_W'(offs_r);
    el_diff   = el_ext - offs_ext;
    el_ge     = el_ext >= offs_ext;
    el_gt     = el_ext > offs_ext;
    div_start = (state_r == rsgg_pkg::ST_PREP) && (dist_r != '0) && el_gt;
  end

  rsgg_div #(
    .DIVIDEND_W (COUNT_WIDTH),
    .DIVISOR_W  (TW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (el_diff[COUNT_WIDTH-1:0]),
    .divisor   (dist_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Result of the tick, formed when the sequence finishes.
  logic                     out_free;
  logic                     finish;
  logic                     final_tick;
  logic                     active_tick;
  logic [rsgg_pkg::BURST_W-1:0] nbursts;
  logic                     in_burst;
  logic [GW-1:0]            gate_clamped;
  logic signed [CW-1:0]     cv_mod_cl;
  logic signed [CW+1:0]     cv_sum;
  logic [GW-1:0]            cv_active;
  logic [GW-1:0]            gate_nxt;
  logic signed [CW-1:0]     cv_nxt;
  logic [PW-1:0]            pulse_base;
  logic                     pulse_now;

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == rsgg_pkg::ST_DONE) && out_free;

  always_comb begin
    final_tick  = running_r && (ticks_left_r == '0);
    active_tick = running_r && (ticks_left_r != '0);
    nbursts     = (num_retrigs_r > rsgg_pkg::BURST_W'(MAX_RETRIGS))
                  ? rsgg_pkg::BURST_W'(MAX_RETRIGS) : num_retrigs_r;
    in_burst    = play_r && (COUNT_WIDTH'(nbursts) > mult_r) && ge_offs_r
                  && (CMP_W'(rem_r) <= CMP_W'(glen_r));

    // Gate input clamped to 0..10 V.
    if (gate_in_r <= 0) begin
      gate_clamped = '0;
    end else if (gate_in_r > $signed({1'b0, rsgg_pkg::FULL_SCALE})) begin
      gate_clamped = rsgg_pkg::FULL_SCALE;
    end else begin
      gate_clamped = gate_in_r[GW-1:0];
    end

    // Active CV: base plus clamped modulation plus optional chained CV.
    if (cv_mod_r > $signed({1'b0, rsgg_pkg::FULL_SCALE})) begin
      cv_mod_cl = $signed({1'b0, rsgg_pkg::FULL_SCALE});
    end else if (cv_mod_r < -$signed({1'b0, rsgg_pkg::FULL_SCALE})) begin
      cv_mod_cl = -$signed({1'b0, rsgg_pkg::FULL_SCALE});
    end else begin
      cv_mod_cl = cv_mod_r;
    end
    cv_sum = $signed({3'b000, cv_base_r}) + {{2{cv_mod_cl[CW-1]}}, cv_mod_cl}
             + (cv_stack_r ? {{2{cv_chain_r[CW-1]}}, cv_chain_r} : '0);
    if (cv_sum < 0) begin
      cv_active = '0;
    end else if (cv_sum > $signed({3'b000, rsgg_pkg::FULL_SCALE})) begin
      cv_active = rsgg_pkg::FULL_SCALE;
    end else begin
      cv_active = cv_sum[GW-1:0];
    end

    // Select the outputs for idle, final and active ticks.
    if (final_tick) begin
      gate_nxt = '0;
      cv_nxt   = '0;
    end else if (active_tick) begin
      if (in_burst) begin
        gate_nxt = mute_r ? '0 : rsgg_pkg::FULL_SCALE;
      end else begin
        gate_nxt = (gate_stack_r && !mute_r) ? gate_clamped : '0;
      end
      cv_nxt = $signed({1'b0, cv_active});
    end else begin
      gate_nxt = gate_clamped;
      cv_nxt   = cv_chain_r;
    end

    pulse_base = final_tick ? PW'(PULSE_TICKS) : pulse_left_r;
    pulse_now  = pulse_base != '0;
  end

  // Sequencer and step state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rsgg_pkg::ST_IDLE;
      running_r    <= 1'b0;
      ticks_left_r <= '0;
      elapsed_r    <= '0;
      play_r       <= 1'b0;
      alt_r        <= 1'b0;
      mute_r       <= 1'b0;
      cv_stack_r   <= 1'b0;
      gate_stack_r <= 1'b0;
      pulse_left_r <= '0;
    end else begin
      case (state_r)
        rsgg_pkg::ST_IDLE: begin
          if (accept) begin
            if (start_now) begin
              ticks_left_r <= ticks_left_nxt;
              elapsed_r    <= '0;
              play_r       <= play_nxt;
              alt_r        <= alt_nxt;
            end
            if (in_ch.cv_stack_toggle) cv_stack_r <= !cv_stack_r;
            if (in_ch.gate_stack_toggle) gate_stack_r <= !gate_stack_r;
            if (in_ch.mute_toggle) mute_r <= !mute_r;
            running_r <= running_nxt;
            if (running_nxt && (ticks_left_nxt != '0)) begin
              state_r <= rsgg_pkg::ST_MUL_GATE;
            end else begin
              state_r <= rsgg_pkg::ST_DONE;
            end
          end
        end
        rsgg_pkg::ST_MUL_GATE:   state_r <= rsgg_pkg::ST_MUL_RETRIG;
        rsgg_pkg::ST_MUL_RETRIG: state_r <= rsgg_pkg::ST_MUL_OFFSET;
        rsgg_pkg::ST_MUL_OFFSET: state_r <= rsgg_pkg::ST_PREP;
        rsgg_pkg::ST_PREP: begin
          state_r <= div_start ? rsgg_pkg::ST_DIV : rsgg_pkg::ST_DONE;
        end
        rsgg_pkg::ST_DIV: begin
          if (div_done) state_r <= rsgg_pkg::ST_DONE;
        end
        rsgg_pkg::ST_DONE: begin
          if (out_free) begin
            state_r <= rsgg_pkg::ST_IDLE;
            if (final_tick) running_r <= 1'b0;
            if (running_r) begin
              if (ticks_left_r != '0) ticks_left_r <= ticks_left_r - 1'b1;
              if (elapsed_r != '1) elapsed_r <= elapsed_r + 1'b1;
            end
            pulse_left_r <= pulse_now ? pulse_base - 1'b1 : pulse_base;
          end
        end
        default: state_r <= rsgg_pkg::ST_IDLE;
      endcase
    end
  end

  // Latched samples, derived tick counts and burst position.
  always_ff @(posedge clk) begin
    if (accept) begin
      gate_in_r  <= in_ch.gate_in;
      cv_mod_r   <= in_ch.cv_mod_in;
      cv_chain_r <= in_ch.cv_chain_in;
    end
    if (state_r == rsgg_pkg::ST_MUL_GATE) glen_r <= frac_ticks;
    if (state_r == rsgg_pkg::ST_MUL_RETRIG) dist_r <= frac_ticks;
    if (state_r == rsgg_pkg::ST_MUL_OFFSET) offs_r <= frac_ticks;
    if (state_r == rsgg_pkg::ST_PREP) begin
      mult_r    <= '0;
      rem_r     <= el_diff[COUNT_WIDTH-1:0];
      ge_offs_r <= el_ge;
    end
    if ((state_r == rsgg_pkg::ST_DIV) && div_done) begin
      mult_r <= div_quo;
      rem_r  <= div_rem;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      gate_out_r      <= gate_nxt;
      cv_out_r        <= cv_nxt;
      end_pulse_r     <= pulse_now && !alt_r;
      alt_end_pulse_r <= pulse_now && alt_r;
      step_active_r   <= active_tick;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.gate_out      = gate_out_r;
  assign out_ch.cv_out        = cv_out_r;
  assign out_ch.end_pulse     = end_pulse_r;
  assign out_ch.alt_end_pulse = alt_end_pulse_r;
  assign out_ch.step_active   = step_active_r;

endmodule

/* test/rsgg_checker.sv */
// Checker for the ratchet step gate generator: tracks the tick state and compares every result word.
module rsgg_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  rsgg_in_if                              in_mon,
  rsgg_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [rsgg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsgg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked,
  output int                              steps_armed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              PULSE_LEN  = 10;
  localparam longint unsigned BURST_MAX  = 64;
  localparam longint unsigned Q16        = rsgg_pkg::Q16_ONE;
  localparam longint          FULL       = rsgg_pkg::FULL_SCALE;
  localparam int              SHOW_LIMIT = 10;
  localparam logic [rsgg_pkg::TICK_W-1:0] AGE_MAX = '1;

  // One input word as seen on the input channel.
  typedef struct {
    bit                                 start;
    bit                                 inhibit;
    bit                                 mute_flip;
    bit                                 cv_chain_flip;
    bit                                 gate_chain_flip;
    logic signed [rsgg_pkg::CODE_W-1:0] gate_code;
    logic signed [rsgg_pkg::CODE_W-1:0] mod_code;
    logic signed [rsgg_pkg::CODE_W-1:0] chain_code;
    logic        [rsgg_pkg::CODE_W-1:0] play_draw;
    logic        [rsgg_pkg::CODE_W-1:0] alt_draw;
  } tick_word_t;

  // One result word, field by field.
  typedef struct {
    logic        [rsgg_pkg::GATE_W-1:0] gate;
    logic signed [rsgg_pkg::CODE_W-1:0] cv;
    logic                               end_p;
    logic                               alt_p;
    logic                               active;
  } tick_result_t;

  // Register copies.
  logic [rsgg_pkg::TICK_W-1:0]  step_len;
  logic [rsgg_pkg::FRAC_W-1:0]  gate_frac, space_frac, lead_frac, play_q16, alt_q16;
  logic [rsgg_pkg::BURST_W-1:0] burst_limit;
  logic [rsgg_pkg::CVB_W-1:0]   base_code;

  // Step state.
  bit                          step_on, will_play, to_alt, muted, cv_chain_on, gate_chain_on;
  logic [rsgg_pkg::TICK_W-1:0] remain, age;
  int                          pulse_count;

  tick_result_t due_outputs[$];

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Tick count of a Q16 share of the current step length.
  function automatic longint unsigned ticks_of(input logic [rsgg_pkg::FRAC_W-1:0] frac);
    longint unsigned f;
    f = frac;
    if (f > Q16) f = Q16;
    return (f * longint'(step_len)) >> 16;
  endfunction

  // Advances the step state by one tick and returns the word the block must produce.
  function automatic tick_result_t gate_cv_for_tick(input tick_word_t w);
    longint          gin, cmod, cch, gate_v, cv_v;
    longint unsigned spacing, glen, offs, bursts, k, first;
    bit              pulse;
    tick_result_t    r;
    gin  = longint'(w.gate_code);
    cmod = longint'(w.mod_code);
    cch  = longint'(w.chain_code);

    // Arm a new step only from idle; the draws are made even if inhibit follows.
    if (!step_on && w.start) begin
      step_on   = 1'b1;
      remain    = step_len;
      age       = '0;
      will_play = (longint'(w.play_draw) + longint'(play_q16)) >= longint'(Q16);
      to_alt    = (longint'(w.alt_draw) + longint'(alt_q16)) > longint'(Q16);
      steps_armed++;
    end
    if (w.cv_chain_flip) cv_chain_on = !cv_chain_on;
    if (w.gate_chain_flip) gate_chain_on = !gate_chain_on;
    if (w.mute_flip) muted = !muted;
    if (w.inhibit) step_on = 1'b0;

    if (step_on) begin
      if (remain == 0) begin
        // Last tick of the step: outputs drop and the end pulse begins.
        step_on     = 1'b0;
        pulse_count = PULSE_LEN;
        gate_v      = 0;
        cv_v        = 0;
      end else begin
        spacing = ticks_of(space_frac);
        glen    = ticks_of(gate_frac);
        offs    = ticks_of(lead_frac);
        bursts  = (burst_limit > BURST_MAX) ? BURST_MAX : burst_limit;
        k       = (spacing > 0 && age > offs) ? (age - offs) / spacing : 0;
        first   = offs + k * spacing;
        if (will_play && k < bursts && age >= first && age <= first + glen) begin
          gate_v = muted ? 0 : FULL;
        end else begin
          gate_v = (gate_chain_on && !muted && gin > 0) ? clip(gin, 0, FULL) : 0;
        end
        cv_v = longint'(base_code) + clip(cmod, -FULL, FULL) + (cv_chain_on ? cch : 0);
        cv_v = clip(cv_v, 0, FULL);
      end
      if (remain != 0) remain--;
      if (age != AGE_MAX) age++;
    end else begin
      gate_v = clip(gin, 0, FULL);
      cv_v   = cch;
    end

    pulse = pulse_count > 0;
    if (pulse_count > 0) pulse_count--;

    r.gate   = gate_v[rsgg_pkg::GATE_W-1:0];
    r.cv     = cv_v[rsgg_pkg::CODE_W-1:0];
    r.end_p  = pulse && !to_alt;
    r.alt_p  = pulse && to_alt;
    r.active = step_on;
    return r;
  endfunction

  // Register writes, result comparison and prediction, all on the rising edge.
  always @(posedge clk) begin
    tick_word_t   w;
    tick_result_t want, got;
    if (!rst_n) begin
      step_len    = 24'd48000;
      gate_frac   = rsgg_pkg::Q16_ONE;
      space_frac  = rsgg_pkg::Q16_ONE;
      lead_frac   = '0;
      burst_limit = 7'd1;
      play_q16    = rsgg_pkg::Q16_ONE;
      alt_q16     = '0;
      base_code   = '0;
      step_on     = 1'b0;
      will_play   = 1'b0;
      to_alt      = 1'b0;
      muted       = 1'b0;
      cv_chain_on = 1'b0;
      gate_chain_on = 1'b0;
      remain      = '0;
      age         = '0;
      pulse_count = 0;
      due_outputs.delete();
    end else begin
      if (cfg_we) begin
        case (rsgg_pkg::cfg_reg_t'(cfg_index))
          rsgg_pkg::CFG_STEP_TICKS:      step_len    = cfg_data[rsgg_pkg::TICK_W-1:0];
          rsgg_pkg::CFG_GATE_FRACTION:   gate_frac   = cfg_data[rsgg_pkg::FRAC_W-1:0];
          rsgg_pkg::CFG_RETRIG_FRACTION: space_frac  = cfg_data[rsgg_pkg::FRAC_W-1:0];
          rsgg_pkg::CFG_OFFSET_FRACTION: lead_frac   = cfg_data[rsgg_pkg::FRAC_W-1:0];
          rsgg_pkg::CFG_NUM_RETRIGS:     burst_limit = cfg_data[rsgg_pkg::BURST_W-1:0];
          rsgg_pkg::CFG_PLAY_PROB:       play_q16    = cfg_data[rsgg_pkg::FRAC_W-1:0];
          rsgg_pkg::CFG_ALT_PROB:        alt_q16     = cfg_data[rsgg_pkg::FRAC_W-1:0];
          rsgg_pkg::CFG_CV_BASE:         base_code   = cfg_data[rsgg_pkg::CVB_W-1:0];
          default: begin
          end
        endcase
      end

      // Compare an accepted result word with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got.gate   = out_mon.gate_out;
        got.cv     = out_mon.cv_out;
        got.end_p  = out_mon.end_pulse;
        got.alt_p  = out_mon.alt_end_pulse;
        got.active = out_mon.step_active;
        if (due_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $display("%0t: result word with nothing expected: %s%0d cv=%0d end=%b alt=%b act=%b",
                     $time, "gate=", got.gate, got.cv, got.end_p, got.alt_p, got.active);
          end
        end else begin
          want = due_outputs.pop_front();
          checked++;
          if (got.gate !== want.gate || got.cv !== want.cv || got.end_p !== want.end_p ||
              got.alt_p !== want.alt_p || got.active !== want.active) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("%0t: result %0d expected gate=%0d cv=%0d end=%b alt=%b act=%b",
                       $time, checked, want.gate, want.cv, want.end_p, want.alt_p, want.active);
              $display("%0t: result %0d got      gate=%0d cv=%0d end=%b alt=%b act=%b",
                       $time, checked, got.gate, got.cv, got.end_p, got.alt_p, got.active);
            end
          end
        end
      end

      // Predict the word caused by an accepted input word.
      if (in_mon.valid && in_mon.ready) begin
        w.start           = in_mon.start_event;
        w.inhibit         = in_mon.inhibit_event;
        w.mute_flip       = in_mon.mute_toggle;
        w.cv_chain_flip   = in_mon.cv_stack_toggle;
        w.gate_chain_flip = in_mon.gate_stack_toggle;
        w.gate_code       = in_mon.gate_in;
        w.mod_code        = in_mon.cv_mod_in;
        w.chain_code      = in_mon.cv_chain_in;
        w.play_draw       = in_mon.rand_play;
        w.alt_draw        = in_mon.rand_alt;
        due_outputs.push_back(gate_cv_for_tick(w));
      end
    end
    pending = due_outputs.size();
  end

endmodule

/* test/tb.sv */
// Top of the testbench: clock, reset, stimulus and verdict for the ratchet step gate generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 14;
  localparam int TAIL_CYCLES = 40;
  localparam int Q16         = 65536;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  rsgg_pkg::cfg_reg_t              cfg_index;
  logic [rsgg_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatches, pending, checked, steps_armed;
  int                              words_sent;
  int                              cycle_count = 0;
  bit                              calm;

  rsgg_in_if  in_ch ();
  rsgg_out_if out_ch ();

  ratchet_step_gate_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsgg_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .steps_armed (steps_armed)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Idle cycles before a word; none at all during calm phases.
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Q16 share with the ends of the range favored.
  function automatic int pick_q16();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return Q16;
      default: return $urandom_range(0, Q16);
    endcase
  endfunction

  // Voltage code: either any 16-bit pattern or a value around the 0..10 V range.
  function automatic int pick_code();
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, 65535);
    return int'($urandom_range(0, 34000)) - 1000;
  endfunction

  // Offers one input word and returns at the edge where it is accepted.
  task automatic push_tick(input bit st, input bit inh, input bit mt, input bit cs, input bit gs,
                           input int gin, input int cmod, input int cch,
                           input int rp, input int ra);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.start_event       <= st;
    in_ch.inhibit_event     <= inh;
    in_ch.mute_toggle       <= mt;
    in_ch.cv_stack_toggle   <= cs;
    in_ch.gate_stack_toggle <= gs;
    in_ch.gate_in           <= rsgg_pkg::CODE_W'(gin);
    in_ch.cv_mod_in         <= rsgg_pkg::CODE_W'(cmod);
    in_ch.cv_chain_in       <= rsgg_pkg::CODE_W'(cch);
    in_ch.rand_play         <= rsgg_pkg::CODE_W'(rp);
    in_ch.rand_alt          <= rsgg_pkg::CODE_W'(ra);
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // Random word: mostly quiet ticks with occasional starts, rare inhibits and toggles.
  task automatic push_random_tick();
    push_tick($urandom_range(0, 4) == 0, $urandom_range(0, 59) == 0,
              $urandom_range(0, 14) == 0, $urandom_range(0, 14) == 0,
              $urandom_range(0, 14) == 0, pick_code(), pick_code(), pick_code(),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic write_reg(input rsgg_pkg::cfg_reg_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rsgg_pkg::CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Waits until every predicted word has come back and the block has gone quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes all eight registers while the block is idle.
  task automatic load_config(input int unsigned st, input int unsigned gf, input int unsigned rf,
                             input int unsigned of, input int unsigned nr, input int unsigned pp,
                             input int unsigned ap, input int unsigned cb);
    drain();
    write_reg(rsgg_pkg::CFG_STEP_TICKS, st);
    write_reg(rsgg_pkg::CFG_GATE_FRACTION, gf);
    write_reg(rsgg_pkg::CFG_RETRIG_FRACTION, rf);
    write_reg(rsgg_pkg::CFG_OFFSET_FRACTION, of);
    write_reg(rsgg_pkg::CFG_NUM_RETRIGS, nr);
    write_reg(rsgg_pkg::CFG_PLAY_PROB, pp);
    write_reg(rsgg_pkg::CFG_ALT_PROB, ap);
    write_reg(rsgg_pkg::CFG_CV_BASE, cb);
    cfg_we <= 1'b0;
  endtask

  // The result side stalls a random number of cycles before each word.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned st;
    int          count;
    in_ch.valid             = 1'b0;
    in_ch.start_event       = 1'b0;
    in_ch.inhibit_event     = 1'b0;
    in_ch.mute_toggle       = 1'b0;
    in_ch.cv_stack_toggle   = 1'b0;
    in_ch.gate_stack_toggle = 1'b0;
    in_ch.gate_in           = '0;
    in_ch.cv_mod_in         = '0;
    in_ch.cv_chain_in       = '0;
    in_ch.rand_play         = '0;
    in_ch.rand_alt          = '0;
    out_ch.ready            = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = rsgg_pkg::CFG_STEP_TICKS;
    cfg_data                = '0;
    calm                    = 1'b0;
    words_sent              = 0;
    rst_n                   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Pass-through at the code extremes with reset settings.
    push_tick(0, 0, 0, 0, 0, -32768, 0, -32768, 0, 0);
    push_tick(0, 0, 0, 0, 0, 32767, 0, 32767, 0, 0);
    push_tick(0, 0, 0, 0, 0, 32001, 0, 0, 0, 0);
    push_tick(0, 0, 0, 0, 0, 1, 0, 32000, 0, 0);
    // Long step that plays: burst, mute, stacking, CV clamps, start while running, inhibit.
    push_tick(1, 0, 0, 0, 0, 100, 0, 0, 0, 65535);
    push_tick(0, 0, 1, 0, 0, 100, 0, 0, 0, 0);
    push_tick(0, 0, 1, 1, 1, 32767, -32768, 32767, 0, 0);
    push_tick(0, 0, 0, 0, 0, 5000, 32767, 32767, 0, 0);
    push_tick(1, 0, 0, 0, 0, 5000, 0, 0, 0, 0);
    push_tick(0, 1, 0, 0, 0, 5000, 0, 0, 0, 0);

    // Silent step with a late, zero-width gate; chained gate passes while the step runs.
    load_config(20, 0, 0, Q16 / 2, 64, 0, Q16, 32000);
    push_tick(1, 0, 0, 0, 0, 5000, 100, -200, 65535, 1);
    push_tick(0, 0, 0, 0, 0, -5, -32768, 0, 0, 0);
    push_tick(0, 0, 0, 0, 1, 20000, 0, 0, 0, 0);
    push_tick(0, 1, 0, 0, 0, 20000, 0, 0, 0, 0);
    push_tick(1, 1, 0, 0, 0, 300, 0, 400, 0, 0);

    // Zero-length steps: end pulse at once, first to the normal and then to the alt output.
    load_config(0, Q16, Q16, 0, 1, Q16, Q16, 0);
    push_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (5) push_tick(0, 0, 0, 0, 0, 1000, 0, 1000, 0, 0);
    push_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    repeat (3) push_tick(0, 0, 0, 0, 0, 1000, 0, 1000, 0, 0);

    // Random phases, each under its own register settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_config(0, 0, 0, 0, 0, 0, 0, 0);
        1: load_config(24'hFFFFFF, Q16, Q16, Q16, 64, Q16, Q16, 32000);
        2: load_config($urandom_range(4, 40), 17'h1FFFF, 17'h1FFFF, 0, 127,
                       17'h1FFFF, 17'h1FFFF, 15'h7FFF);
        3: load_config($urandom_range(4, 40), pick_q16(), pick_q16(), 17'h1FFFF,
                       $urandom_range(1, 8), pick_q16(), pick_q16(), $urandom_range(0, 32000));
        default: begin
          case ($urandom_range(0, 11))
            0: st = $urandom_range(0, 2);
            1: st = $urandom_range(100, 400);
            2: st = $urandom_range(0, 24'hFFFFFF);
            default: st = $urandom_range(3, 60);
          endcase
          load_config(st, pick_q16(), pick_q16(), pick_q16(),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 8),
                      pick_q16(), pick_q16(),
                      ($urandom_range(0, 5) == 0) ? 32000 : $urandom_range(0, 32000));
        end
      endcase
      calm  = (p % 4 == 3);
      count = (p == 1) ? 40 : 93;
      repeat (count) push_random_tick();
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d words in %0d register settings", words_sent, PHASES + 3);
    $display("summary: %0d results compared, %0d steps armed", checked, steps_armed);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
